// File: design/retransmit_request_table_assert.svh
`ifndef RETRANSMIT_REQUEST_TABLE_ASSERT_SVH
`define RETRANSMIT_REQUEST_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("retransmit request table check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("retransmit request table check failed");

`endif

// File: design/rrt_pkg.sv
`timescale 1ns / 1ps
package rrt_pkg;

  localparam int MAX_REQ     = 64;
  localparam int TABLE_DEPTH = 2048;
  localparam int BLOCK_BITS  = 16;

  localparam int BLK_W     = 16;
  localparam int CNT_OUT_W = 7;
  localparam int TAB_AW    = $clog2(TABLE_DEPTH);
  localparam int FILL_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W     = $clog2(MAX_REQ + 1);
  localparam int ROW_SEL_W = 4;
  localparam int ROW_BITS  = 1 << ROW_SEL_W;
  localparam int MAP_AW    = BLOCK_BITS - ROW_SEL_W;
  localparam int MAP_ROWS  = 1 << MAP_AW;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_MARK = 2'd0,
    OP_REQ  = 2'd1,
    OP_PASS = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_RETRANS = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRE_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE = 2'd2;

  typedef struct packed {
    logic              re;
    logic [TAB_AW-1:0] raddr;
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic [BLK_W-1:0]  wdata;
  } tab_req_t;

  typedef struct packed {
    logic                rd_en;
    logic [MAP_AW-1:0]   rd_row;
    logic                wr_en;
    logic [MAP_AW-1:0]   wr_row;
    logic [ROW_BITS-1:0] wr_data;
  } map_req_t;

  function automatic logic [BLOCK_BITS-1:0] map_index(input logic [BLK_W-1:0] b);
    return BLOCK_BITS'(b);
  endfunction

endpackage

// File: design/rrt_if.sv
`timescale 1ns / 1ps
interface rrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] block;
  logic [15:0] gapless_to;

  modport source (output valid, op, block, gapless_to, input ready);
  modport sink (input valid, op, block, gapless_to, output ready);
endinterface

interface rrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] block_out;
  logic [15:0] wire_clear_at;
  logic [6:0]  count;
  logic        dropped;
  logic        last;

  modport source (output valid, kind, block_out, wire_clear_at, count, dropped, last,
                  input ready);
  modport sink (input valid, kind, block_out, wire_clear_at, count, dropped, last,
                output ready);
endinterface

// File: design/rrt_req_mem.sv
`timescale 1ns / 1ps
module rrt_req_mem
  import rrt_pkg::*;
(
  input  logic             clk,
  input  tab_req_t         req,
  output logic [BLK_W-1:0] rdata
);

  logic [BLK_W-1:0] mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read, hold when idle
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: design/rrt_rx_map.sv
`timescale 1ns / 1ps
module rrt_rx_map
  import rrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  map_req_t            req,
  output logic [ROW_BITS-1:0] rdata,
  output logic                busy
);

  logic [ROW_BITS-1:0] mem [MAP_ROWS];
  logic [MAP_AW-1:0]   clr_row;
  logic                clearing;

  // sweep all rows to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == MAP_AW'(MAP_ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;

  // write port, sweep has priority
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
  end

  // registered read, hold when idle
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_row];
    end
  end

endmodule

// File: design/rrt_ctrl.sv
`timescale 1ns / 1ps
`include "retransmit_request_table_assert.svh"
module rrt_ctrl
  import rrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  rrt_in_if.sink              in_ch,
  rrt_out_if.source           out_ch,
  input  logic [BLK_W-1:0]    block_total,
  input  logic [BLK_W-1:0]    wire_blocks,
  input  logic                sorted_mode,
  output tab_req_t            tab_req,
  input  logic [BLK_W-1:0]    tab_rdata,
  output map_req_t            map_req,
  input  logic [ROW_BITS-1:0] map_rdata,
  input  logic                map_busy
);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_MK_RD   = 18'h00002,
    ST_MK_WR   = 18'h00004,
    ST_RQ_RD   = 18'h00008,
    ST_RQ_CHK  = 18'h00010,
    ST_SR_RD   = 18'h00020,
    ST_SR_CMP  = 18'h00040,
    ST_SH_RD   = 18'h00080,
    ST_SH_WR   = 18'h00100,
    ST_PS_RD   = 18'h00200,
    ST_PS_MAP  = 18'h00400,
    ST_PS_CHK  = 18'h00800,
    ST_PS_END  = 18'h01000,
    ST_PS_RST  = 18'h02000,
    ST_EM_RD   = 18'h04000,
    ST_EM_OUT  = 18'h08000,
    ST_EM_DONE = 18'h10000,
    ST_ACK     = 18'h20000
  } state_t;

  state_t              state, state_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [FILL_W-1:0]   e, e_next;
  logic [FILL_W-1:0]   pos, pos_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [BLK_W-1:0]    hold, hold_next;
  logic                drop, drop_next;
  logic [BLK_W-1:0]    cur_blk, cur_gap;

  logic                  ov, ov_next;
  logic [1:0]            okind, okind_next;
  logic [BLK_W-1:0]      oblk, oblk_next;
  logic [BLK_W-1:0]      oclr, oclr_next;
  logic [CNT_OUT_W-1:0]  ocnt, ocnt_next;
  logic                  odrop, odrop_next;
  logic                  olast, olast_next;

  logic                  in_acc, can_emit;
  logic [BLOCK_BITS-1:0] cur_idx, hold_idx, rd_idx;
  logic [BLK_W:0]        start_w, clr_w;
  logic [BLK_W-1:0]      start_cl, clr_cl;
  logic [FILL_W-1:0]     fill_m1;

  function automatic logic [TAB_AW-1:0] fill_w_addr(input logic [FILL_W-1:0] a);
    return a[TAB_AW-1:0];
  endfunction

  assign in_ch.ready = (state == ST_IDLE) && !map_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign can_emit    = !ov || out_ch.ready;

  assign cur_idx  = map_index(cur_blk);
  assign hold_idx = map_index(hold);
  assign rd_idx   = map_index(tab_rdata);
  assign fill_m1  = fill - FILL_W'(1);

  // clamp restart point and clear point to the transfer size
  assign start_w  = {1'b0, cur_gap} + (BLK_W + 1)'(1);
  assign clr_w    = {1'b0, tab_rdata} + {1'b0, wire_blocks};
  assign start_cl = (start_w > {1'b0, block_total}) ? block_total : start_w[BLK_W-1:0];
  assign clr_cl   = (clr_w > {1'b0, block_total}) ? block_total : clr_w[BLK_W-1:0];

  // sequencer: read, check, write back, emit results
  always_comb begin
    state_next = state;
    fill_next  = fill;
    e_next     = e;
    pos_next   = pos;
    cnt_next   = cnt;
    hold_next  = hold;
    drop_next  = drop;
    ov_next    = ov && !out_ch.ready;
    okind_next = okind;
    oblk_next  = oblk;
    oclr_next  = oclr;
    ocnt_next  = ocnt;
    odrop_next = odrop;
    olast_next = olast;
    tab_req    = '0;
    map_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_ch.op))
            OP_MARK: state_next = ST_MK_RD;
            OP_REQ:  state_next = ST_RQ_RD;
            OP_PASS: begin
              e_next     = '0;
              cnt_next   = '0;
              state_next = ST_PS_RD;
            end
            default: begin
              drop_next  = 1'b0;
              state_next = ST_ACK;
            end
          endcase
        end
      end
      ST_MK_RD: begin
        map_req.rd_en  = 1'b1;
        map_req.rd_row = cur_idx[BLOCK_BITS-1:ROW_SEL_W];
        state_next     = ST_MK_WR;
      end
      ST_MK_WR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_row  = cur_idx[BLOCK_BITS-1:ROW_SEL_W];
        map_req.wr_data = map_rdata | (ROW_BITS'(1) << cur_idx[ROW_SEL_W-1:0]);
        drop_next       = 1'b0;
        state_next      = ST_ACK;
      end
      ST_RQ_RD: begin
        map_req.rd_en  = 1'b1;
        map_req.rd_row = cur_idx[BLOCK_BITS-1:ROW_SEL_W];
        state_next     = ST_RQ_CHK;
      end
      ST_RQ_CHK: begin
        if (fill >= FILL_W'(TABLE_DEPTH) || map_rdata[cur_idx[ROW_SEL_W-1:0]]) begin
          drop_next  = 1'b1;
          state_next = ST_ACK;
        end else if (!sorted_mode) begin
          tab_req.we    = 1'b1;
          tab_req.waddr = fill[TAB_AW-1:0];
          tab_req.wdata = cur_blk;
          fill_next     = fill + FILL_W'(1);
          drop_next     = 1'b0;
          state_next    = ST_ACK;
        end else begin
          e_next     = '0;
          state_next = ST_SR_RD;
        end
      end
      // find the first entry not below the new block
      ST_SR_RD: begin
        if (e < fill) begin
          tab_req.re    = 1'b1;
          tab_req.raddr = e[TAB_AW-1:0];
          state_next    = ST_SR_CMP;
        end else begin
          pos_next   = e;
          e_next     = fill;
          state_next = ST_SH_RD;
        end
      end
      ST_SR_CMP: begin
        if (tab_rdata < cur_blk) begin
          e_next     = e + FILL_W'(1);
          state_next = ST_SR_RD;
        end else if (tab_rdata == cur_blk) begin
          drop_next  = 1'b1;
          state_next = ST_ACK;
        end else begin
          pos_next   = e;
          e_next     = fill;
          state_next = ST_SH_RD;
        end
      end
      // shift the tail up one place, then insert
      ST_SH_RD: begin
        if (e > pos) begin
          tab_req.re    = 1'b1;
          tab_req.raddr = fill_w_addr(e - FILL_W'(1));
          state_next    = ST_SH_WR;
        end else begin
          tab_req.we    = 1'b1;
          tab_req.waddr = pos[TAB_AW-1:0];
          tab_req.wdata = cur_blk;
          fill_next     = fill + FILL_W'(1);
          drop_next     = 1'b0;
          state_next    = ST_ACK;
        end
      end
      ST_SH_WR: begin
        tab_req.we    = 1'b1;
        tab_req.waddr = e[TAB_AW-1:0];
        tab_req.wdata = tab_rdata;
        e_next        = e - FILL_W'(1);
        state_next    = ST_SH_RD;
      end
      // compact: keep entries that are nonzero and not yet received
      ST_PS_RD: begin
        if (e < fill && cnt < CNT_W'(MAX_REQ)) begin
          tab_req.re    = 1'b1;
          tab_req.raddr = e[TAB_AW-1:0];
          state_next    = ST_PS_MAP;
        end else begin
          state_next = ST_PS_END;
        end
      end
      ST_PS_MAP: begin
        hold_next      = tab_rdata;
        map_req.rd_en  = 1'b1;
        map_req.rd_row = rd_idx[BLOCK_BITS-1:ROW_SEL_W];
        state_next     = ST_PS_CHK;
      end
      ST_PS_CHK: begin
        if (hold != '0 && !map_rdata[hold_idx[ROW_SEL_W-1:0]]) begin
          tab_req.we    = 1'b1;
          tab_req.waddr = TAB_AW'(cnt);
          tab_req.wdata = hold;
          cnt_next      = cnt + CNT_W'(1);
        end
        e_next     = e + FILL_W'(1);
        state_next = ST_PS_RD;
      end
      ST_PS_END: begin
        if (cnt >= CNT_W'(MAX_REQ)) begin
          tab_req.re    = 1'b1;
          tab_req.raddr = fill_m1[TAB_AW-1:0];
          state_next    = ST_PS_RST;
        end else begin
          fill_next  = FILL_W'(cnt);
          e_next     = '0;
          state_next = ST_EM_RD;
        end
      end
      ST_PS_RST: begin
        if (can_emit) begin
          ov_next    = 1'b1;
          okind_next = KIND_RESTART;
          oblk_next  = start_cl;
          oclr_next  = clr_cl;
          ocnt_next  = CNT_OUT_W'(MAX_REQ);
          odrop_next = 1'b0;
          olast_next = 1'b1;
          fill_next  = '0;
          state_next = ST_IDLE;
        end
      end
      // replay the surviving entries
      ST_EM_RD: begin
        if (e < FILL_W'(cnt)) begin
          tab_req.re    = 1'b1;
          tab_req.raddr = e[TAB_AW-1:0];
          state_next    = ST_EM_OUT;
        end else begin
          state_next = ST_EM_DONE;
        end
      end
      ST_EM_OUT: begin
        if (can_emit) begin
          ov_next    = 1'b1;
          okind_next = KIND_RETRANS;
          oblk_next  = tab_rdata;
          oclr_next  = '0;
          ocnt_next  = CNT_OUT_W'(cnt);
          odrop_next = 1'b0;
          olast_next = 1'b0;
          e_next     = e + FILL_W'(1);
          state_next = ST_EM_RD;
        end
      end
      ST_EM_DONE: begin
        if (can_emit) begin
          ov_next    = 1'b1;
          okind_next = KIND_DONE;
          oblk_next  = '0;
          oclr_next  = '0;
          ocnt_next  = CNT_OUT_W'(cnt);
          odrop_next = 1'b0;
          olast_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (can_emit) begin
          ov_next    = 1'b1;
          okind_next = KIND_ACK;
          oblk_next  = '0;
          oclr_next  = '0;
          ocnt_next  = '0;
          odrop_next = drop;
          olast_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ov    <= ov_next;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    e     <= e_next;
    pos   <= pos_next;
    cnt   <= cnt_next;
    hold  <= hold_next;
    drop  <= drop_next;
    okind <= okind_next;
    oblk  <= oblk_next;
    oclr  <= oclr_next;
    ocnt  <= ocnt_next;
    odrop <= odrop_next;
    olast <= olast_next;
    if (in_acc) begin
      cur_blk <= in_ch.block;
      cur_gap <= in_ch.gapless_to;
    end
  end

  assign out_ch.valid         = ov;
  assign out_ch.kind          = okind;
  assign out_ch.block_out     = oblk;
  assign out_ch.wire_clear_at = oclr;
  assign out_ch.count         = ocnt;
  assign out_ch.dropped       = odrop;
  assign out_ch.last          = olast;

  `RRT_ASSERT_IMP(a_fill_limit, 1'b1, fill <= FILL_W'(TABLE_DEPTH))
  `RRT_ASSERT_NXT(a_accept_leaves_idle, in_acc, state != ST_IDLE)
  `RRT_ASSERT_IMP(a_compact_behind_scan, state == ST_PS_CHK && tab_req.we, FILL_W'(cnt) <= e)
  `RRT_ASSERT_IMP(a_no_accept_while_clearing, map_busy, !in_ch.ready)

endmodule

// File: design/retransmit_request_table.sv
`timescale 1ns / 1ps
// Retransmit request table: keeps the missing block numbers of a bulk transfer in a
// 2048-entry table memory and the received blocks in a bitmap memory of 16-bit rows.
// One request at a time is worked on, by a sequencer with registered memory reads.
// A mark reads its bitmap row and writes it back; an unsorted request checks the
// bitmap and appends to the table; a sorted request scans for its place and shifts
// the tail up; a repeat pass reads each entry and its bitmap row, then emits the
// retransmit requests. After reset the bitmap is swept clear, one row a cycle over
// all 4096 rows, during which no request is taken; configuration writes are taken at
// any time and should be done while idle.
module retransmit_request_table
  import rrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLK_W-1:0]     cfg_data,
  rrt_in_if.sink               in_ch,
  rrt_out_if.source            out_ch
);

  logic [BLK_W-1:0]    block_total;
  logic [BLK_W-1:0]    wire_blocks;
  logic                sorted_mode;
  tab_req_t            tab_req;
  logic [BLK_W-1:0]    tab_rdata;
  map_req_t            map_req;
  logic [ROW_BITS-1:0] map_rdata;
  logic                map_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_total <= '0;
      wire_blocks <= '0;
      sorted_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_TOTAL: block_total <= cfg_data;
        CFG_WIRE_BLOCKS: wire_blocks <= cfg_data;
        CFG_SORTED_MODE: sorted_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rrt_req_mem u_req_mem (
    .clk   (clk),
    .req   (tab_req),
    .rdata (tab_rdata)
  );

  rrt_rx_map u_rx_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .rdata (map_rdata),
    .busy  (map_busy)
  );

  rrt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .block_total (block_total),
    .wire_blocks (wire_blocks),
    .sorted_mode (sorted_mode),
    .tab_req     (tab_req),
    .tab_rdata   (tab_rdata),
    .map_req     (map_req),
    .map_rdata   (map_rdata),
    .map_busy    (map_busy)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rrt_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  typedef struct {
    op_t         op;
    logic [15:0] block;
    logic [15:0] gapless_to;
  } request_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] block_out;
    logic [15:0] wire_clear_at;
    logic [6:0]  count;
    logic        dropped;
    logic        last;
  } result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLK_W-1:0] cfg_data;

  rrt_in_if in_ch ();
  rrt_out_if out_ch ();

  retransmit_request_table u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Shadow state of the table
  logic [15:0] miss_tab [0:TABLE_DEPTH-1];
  int unsigned miss_fill;
  bit          got_map [0:65535];
  logic [15:0] xfer_blocks;
  logic [15:0] flight_blocks;
  logic        keep_sorted;

  request_t pending_requests[$];
  result_t  expected_results[$];
  int       mismatches;
  int       results_seen;
  int       idle_cycles;
  int       in_flight;
  bit       no_gaps;

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic result_t make_result(kind_t k, logic [15:0] b, logic [15:0] c,
                                          logic [6:0] n, logic d, logic l);
    result_t r;
    r.kind = k; r.block_out = b; r.wire_clear_at = c; r.count = n; r.dropped = d; r.last = l;
    return r;
  endfunction

  // Try to add a missing block; return 1 when the request is dropped
  function automatic logic add_missing(logic [15:0] b);
    int unsigned idx;
    if (got_map[b] || miss_fill >= TABLE_DEPTH) return 1'b1;
    if (!keep_sorted) begin
      miss_tab[miss_fill] = b;
      miss_fill++;
      return 1'b0;
    end
    idx = 0;
    while (idx < miss_fill && miss_tab[idx] < b) idx++;
    if (idx < miss_fill && miss_tab[idx] == b) return 1'b1;
    for (int unsigned j = miss_fill; j > idx; j--) miss_tab[j] = miss_tab[j-1];
    miss_tab[idx] = b;
    miss_fill++;
    return 1'b0;
  endfunction

  // Compact the table and queue the retransmit or restart results
  task automatic predict_pass(logic [15:0] gapless);
    int unsigned n;
    logic [31:0] start;
    logic [31:0] clear_pt;
    n = 0;
    for (int unsigned e = 0; e < miss_fill && n < MAX_REQ; e++) begin
      if (miss_tab[e] != 0 && !got_map[miss_tab[e]]) begin
        miss_tab[n] = miss_tab[e];
        n++;
      end
    end
    if (n >= MAX_REQ) begin
      start = 32'(gapless) + 1;
      clear_pt = 32'(miss_tab[miss_fill-1]) + 32'(flight_blocks);
      if (start > xfer_blocks) start = xfer_blocks;
      if (clear_pt > xfer_blocks) clear_pt = xfer_blocks;
      miss_fill = 0;
      expected_results.push_back(make_result(KIND_RESTART, start[15:0], clear_pt[15:0],
                                             7'(MAX_REQ), 1'b0, 1'b1));
    end else begin
      miss_fill = n;
      for (int unsigned i = 0; i < n; i++)
        expected_results.push_back(make_result(KIND_RETRANS, miss_tab[i], 16'd0, 7'(n),
                                               1'b0, 1'b0));
      expected_results.push_back(make_result(KIND_DONE, 16'd0, 16'd0, 7'(n), 1'b0, 1'b1));
    end
  endtask

  task automatic predict_request(request_t r);
    logic d;
    d = 1'b0;
    case (r.op)
      OP_MARK: got_map[r.block] = 1'b1;
      OP_REQ:  d = add_missing(r.block);
      OP_PASS: begin
        predict_pass(r.gapless_to);
        return;
      end
      default: ;
    endcase
    expected_results.push_back(make_result(KIND_ACK, 16'd0, 16'd0, 7'd0, d, 1'b1));
  endtask

  // Driver: offer pending requests with random gaps
  int unsigned send_gap;
  request_t    cur_req;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_request(cur_req);
        nv = 1'b0;
        send_gap = no_gaps ? 0 : $urandom_range(0, 17);
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          in_flight++;
          in_ch.op <= cur_req.op;
          in_ch.block <= cur_req.block;
          in_ch.gapless_to <= cur_req.gapless_to;
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
    end
  end

  // Monitor: accept results with random stalls, one long hold-off
  int unsigned recv_stall;
  int unsigned hold_off;
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
      hold_off = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.last) in_flight--;
        if (results_seen == 40) hold_off = 2500;
        recv_stall = no_gaps ? 0 : $urandom_range(0, 17);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind=%0d", out_ch.kind);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.block_out !== want.block_out ||
              out_ch.wire_clear_at !== want.wire_clear_at || out_ch.count !== want.count ||
              out_ch.dropped !== want.dropped || out_ch.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp k=%0d b=%0d c=%0d n=%0d d=%0d l=%0d",
                       want.kind, want.block_out, want.wire_clear_at, want.count,
                       want.dropped, want.last);
              $display("         got k=%0d b=%0d c=%0d n=%0d d=%0d l=%0d",
                       out_ch.kind, out_ch.block_out, out_ch.wire_clear_at,
                       out_ch.count, out_ch.dropped, out_ch.last);
            end
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BLOCK_TOTAL: xfer_blocks = val;
      CFG_WIRE_BLOCKS: flight_blocks = val;
      default:         keep_sorted = val[0];
    endcase
  endtask

  task automatic set_config(logic [15:0] tot, logic [15:0] wire_n, logic srt);
    write_reg(CFG_BLOCK_TOTAL, tot);
    write_reg(CFG_WIRE_BLOCKS, wire_n);
    write_reg(CFG_SORTED_MODE, {15'd0, srt});
  endtask

  task automatic push_req(op_t op, logic [15:0] b, logic [15:0] g);
    request_t r;
    r.op = op; r.block = b; r.gapless_to = g;
    pending_requests.push_back(r);
  endtask

  // Hold until every request is sent and every result has arrived
  task automatic drain();
    while (pending_requests.size() > 0 || in_ch.valid || in_flight > 0 ||
           expected_results.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_block();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom);
  endfunction

  // Mix of marks, requests, passes and random ops
  task automatic push_random(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) push_req(OP_REQ, pick_block(), 16'($urandom));
      else if (r < 80) push_req(OP_MARK, pick_block(), 16'($urandom));
      else if (r < 93) push_req(OP_PASS, 16'($urandom), 16'($urandom));
      else push_req(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_MARK;
    in_ch.block = '0;
    in_ch.gapless_to = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    miss_fill = 0;
    xfer_blocks = 0;
    flight_blocks = 0;
    keep_sorted = 0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    in_flight = 0;
    no_gaps = 0;
    foreach (got_map[i]) got_map[i] = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: edge blocks, zero entry, duplicates, unknown op
    set_config(16'hFFFF, 16'd0, 1'b0);
    push_req(OP_REQ, 16'd0, 16'd0);
    push_req(OP_REQ, 16'hFFFF, 16'hFFFF);
    push_req(OP_MARK, 16'hFFFF, 16'd0);
    push_req(OP_REQ, 16'hFFFF, 16'd0);
    push_req(OP_REQ, 16'd5, 16'd0);
    push_req(OP_REQ, 16'd5, 16'd0);
    push_req(OP_NONE, 16'hA5A5, 16'h5A5A);
    push_req(OP_PASS, 16'd0, 16'd0);
    push_req(OP_MARK, 16'd5, 16'd0);
    push_req(OP_PASS, 16'd0, 16'hFFFF);
    drain();

    // Sorted insertion, duplicate drop
    set_config(16'hFFFF, 16'd100, 1'b1);
    push_req(OP_REQ, 16'd10, 16'd0);
    push_req(OP_REQ, 16'd3, 16'd0);
    push_req(OP_REQ, 16'd10, 16'd0);
    push_req(OP_REQ, 16'd7, 16'd0);
    push_req(OP_REQ, 16'd0, 16'd0);
    push_req(OP_REQ, 16'hFFFE, 16'd0);
    push_req(OP_PASS, 16'd0, 16'd1);
    drain();

    // Fill past the request limit, then restart with capped points
    set_config(16'd1000, 16'hFFFF, 1'b0);
    for (int i = 0; i < 66; i++) push_req(OP_REQ, 16'($urandom_range(1, 65535)), 16'd0);
    push_req(OP_PASS, 16'hFFFF, 16'hFFFF);
    drain();

    // Random phases over several settings
    set_config(16'd0, 16'd0, 1'b1);
    push_random(35);
    drain();
    no_gaps = 1;
    set_config(16'($urandom), 16'($urandom_range(0, 300)), 1'b0);
    push_random(35);
    drain();
    no_gaps = 0;
    set_config(16'hFFFF, 16'hFFFF, 1'b1);
    push_random(35);
    drain();
    set_config(16'($urandom), 16'($urandom), 1'b0);
    push_random(35);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
